// File: rtl/tar4_pkg.sv
// ----------------------------------------------------------------------------
// tar4_pkg
// Types, constants and helper functions shared by the Thomas attractor
// RK4 step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tar4_pkg;

    localparam int MAX_BLOCK_DEF = 64;

    // Datapath widths: wide signed operand, narrow signed operand, product.
    localparam int RW = 48;
    localparam int BW = 34;
    localparam int PW = RW + BW;
    localparam int HALF = RW / 2;

    localparam logic signed [31:0] POS_X_RST = 32'sd53687091;
    localparam logic signed [31:0] POS_Y_RST = 32'sd40265318;
    localparam logic signed [31:0] POS_Z_RST = 32'sd13421773;

    localparam logic signed [RW-1:0] Q30_TWO_PI  = 48'sd6746518852;
    localparam logic signed [RW-1:0] Q30_PI      = 48'sd3373259426;
    localparam logic signed [RW-1:0] Q30_HALF_PI = 48'sd1686629713;
    localparam logic signed [BW-1:0] Q30_SIXTH   = 34'sd178956971;
    localparam logic signed [BW-1:0] HORNER_SEED = 34'sd27;
    localparam logic signed [RW-1:0] SAT_MAX     = 48'sd2147483647;
    localparam logic signed [RW-1:0] SAT_MIN     = -48'sd2147483648;

    typedef struct packed {
        logic [23:0] step_size;
        logic [23:0] damping;
        logic [6:0]  sample_count;
    } req_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               block_last;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [23:0] dt;
        logic [23:0] damp;
    } rk_cmd_t;

    typedef struct packed {
        logic                 start;
        logic signed [RW-1:0] a;
        logic signed [BW-1:0] b;
    } mul_req_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_START,
        TS_RUN,
        TS_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ARG,
        CS_RED,
        CS_FOLD,
        CS_MGO,
        CS_MWAIT,
        CS_DONE
    } core_state_t;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_HORN,
        OP_SINF,
        OP_BU,
        OP_DK,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI
    } mul_phase_t;

    // Sine polynomial coefficients in Q3.30, in Horner order.
    function automatic logic signed [BW-1:0] horner_coef(input logic [2:0] idx);
        logic signed [BW-1:0] c;
        case (idx)
            3'd0:    c = 34'sd2959;
            3'd1:    c = 34'sd213044;
            3'd2:    c = 34'sd8947849;
            3'd3:    c = 34'sd178956971;
            default: c = 34'sd1073741824;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tar4_mul.sv
// ----------------------------------------------------------------------------
// tar4_mul
// Shared signed multiplier: a 48-bit operand times a 34-bit operand, built
// from two 25 x 34 partial products taken in consecutive cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module tar4_mul (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tar4_pkg::mul_req_t             req,
    output logic                                done,
    output logic signed [tar4_pkg::PW-1:0]      prod
);

    tar4_pkg::mul_phase_t phase_reg;
    logic                              done_reg;
    logic signed [tar4_pkg::RW-1:0]    a_reg;
    logic signed [tar4_pkg::BW-1:0]    b_reg;
    logic signed [tar4_pkg::PW-1:0]    acc_reg;
    logic signed [tar4_pkg::HALF:0]    m_op;
    logic signed [tar4_pkg::HALF+tar4_pkg::BW:0] m_res;

    // The low half is unsigned, the high half carries the sign.
    always_comb
    begin
        if (phase_reg == tar4_pkg::MP_LO)
        begin
            m_op = $signed({1'b0, a_reg[tar4_pkg::HALF-1:0]});
        end
        else
        begin
            m_op = $signed({a_reg[tar4_pkg::RW-1], a_reg[tar4_pkg::RW-1:tar4_pkg::HALF]});
        end
        m_res = m_op * b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tar4_pkg::MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                tar4_pkg::MP_IDLE:
                begin
                    if (req.start)
                    begin
                        phase_reg <= tar4_pkg::MP_LO;
                    end
                end
                tar4_pkg::MP_LO:
                begin
                    phase_reg <= tar4_pkg::MP_HI;
                end
                tar4_pkg::MP_HI:
                begin
                    phase_reg <= tar4_pkg::MP_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    phase_reg <= tar4_pkg::MP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == tar4_pkg::MP_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (phase_reg == tar4_pkg::MP_LO)
        begin
            acc_reg <= tar4_pkg::PW'(m_res);
        end
        else if (phase_reg == tar4_pkg::MP_HI)
        begin
            acc_reg <= acc_reg + (tar4_pkg::PW'(m_res) <<< tar4_pkg::HALF);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// File: rtl/tar4_core.sv
// ----------------------------------------------------------------------------
// tar4_core
// Sequencer for one RK4 step: twelve slope evaluations with polynomial sine
// and three final updates, all products going through the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tar4_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tar4_pkg::rk_cmd_t    cmd,
    output logic                      done,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic signed [31:0]        pos_z
);

    localparam int RW = tar4_pkg::RW;
    localparam int BW = tar4_pkg::BW;
    localparam int PW = tar4_pkg::PW;

    tar4_pkg::core_state_t state_reg;
    tar4_pkg::core_state_t state_next;
    tar4_pkg::op_t         op_reg;
    tar4_pkg::mul_req_t    mreq;
    logic                  mul_done;
    logic signed [PW-1:0]  prod;

    logic [1:0] comp_reg;
    logic [1:0] stage_reg;
    logic [2:0] hcnt_reg;

    // Lanes rotate after each component so that the current one sits at 0.
    logic signed [31:0]   pos_reg   [3];
    logic signed [RW-1:0] kprev_reg [3];
    logic signed [RW-1:0] kcur_reg  [3];
    logic signed [RW-1:0] ksum_reg  [3];

    logic signed [RW-1:0] u_reg;
    logic signed [RW-1:0] r_reg;
    logic signed [RW-1:0] r2_reg;
    logic signed [RW-1:0] sin_reg;
    logic signed [RW-1:0] d_reg;
    logic signed [BW-1:0] p_reg;

    logic                 r_in_range;
    logic signed [RW-1:0] k_new;
    logic signed [RW-1:0] pos_sum;
    logic signed [31:0]   pos_sat;

    function automatic logic signed [RW-1:0] half_k(input logic [1:0] stage,
                                                    input logic signed [RW-1:0] k);
        logic signed [RW-1:0] h;
        case (stage)
            2'd0:    h = '0;
            2'd3:    h = k;
            default: h = k >>> 1;
        endcase
        return h;
    endfunction

    tar4_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (prod)
    );

    assign r_in_range = (r_reg < tar4_pkg::Q30_PI) && (r_reg >= -tar4_pkg::Q30_PI);
    assign k_new      = RW'(prod >>> 24);
    assign pos_sum    = RW'(pos_reg[0]) + RW'(prod >>> 30);

    always_comb
    begin
        if (pos_sum > tar4_pkg::SAT_MAX)
        begin
            pos_sat = 32'(tar4_pkg::SAT_MAX);
        end
        else if (pos_sum < tar4_pkg::SAT_MIN)
        begin
            pos_sat = 32'(tar4_pkg::SAT_MIN);
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tar4_pkg::CS_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = tar4_pkg::CS_ARG;
                end
            end
            tar4_pkg::CS_ARG:   state_next = tar4_pkg::CS_RED;
            tar4_pkg::CS_RED:
            begin
                if (r_in_range)
                begin
                    state_next = tar4_pkg::CS_FOLD;
                end
            end
            tar4_pkg::CS_FOLD:  state_next = tar4_pkg::CS_MGO;
            tar4_pkg::CS_MGO:   state_next = tar4_pkg::CS_MWAIT;
            tar4_pkg::CS_MWAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        tar4_pkg::OP_DK:
                        begin
                            if (comp_reg == 2'd2 && stage_reg == 2'd3)
                            begin
                                state_next = tar4_pkg::CS_MGO;
                            end
                            else
                            begin
                                state_next = tar4_pkg::CS_ARG;
                            end
                        end
                        tar4_pkg::OP_FIN:
                        begin
                            if (comp_reg == 2'd2)
                            begin
                                state_next = tar4_pkg::CS_DONE;
                            end
                            else
                            begin
                                state_next = tar4_pkg::CS_MGO;
                            end
                        end
                        default: state_next = tar4_pkg::CS_MGO;
                    endcase
                end
            end
            tar4_pkg::CS_DONE:  state_next = tar4_pkg::CS_IDLE;
            default:            state_next = tar4_pkg::CS_IDLE;
        endcase
    end

    // Outputs and multiplier operand selection
    always_comb
    begin
        mreq.start = (state_reg == tar4_pkg::CS_MGO);
        done       = (state_reg == tar4_pkg::CS_DONE);
        case (op_reg)
            tar4_pkg::OP_SQ:
            begin
                mreq.a = r_reg;
                mreq.b = BW'(r_reg);
            end
            tar4_pkg::OP_HORN:
            begin
                mreq.a = r2_reg;
                mreq.b = p_reg;
            end
            tar4_pkg::OP_SINF:
            begin
                mreq.a = r_reg;
                mreq.b = p_reg;
            end
            tar4_pkg::OP_BU:
            begin
                mreq.a = u_reg;
                mreq.b = $signed({{(BW-24){1'b0}}, cmd.damp});
            end
            tar4_pkg::OP_DK:
            begin
                mreq.a = d_reg;
                mreq.b = $signed({{(BW-24){1'b0}}, cmd.dt});
            end
            default:
            begin
                mreq.a = ksum_reg[0];
                mreq.b = tar4_pkg::Q30_SIXTH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tar4_pkg::CS_IDLE;
            op_reg     <= tar4_pkg::OP_SQ;
            comp_reg   <= 2'd0;
            stage_reg  <= 2'd0;
            hcnt_reg   <= 3'd0;
            pos_reg[0] <= tar4_pkg::POS_X_RST;
            pos_reg[1] <= tar4_pkg::POS_Y_RST;
            pos_reg[2] <= tar4_pkg::POS_Z_RST;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                tar4_pkg::CS_IDLE:
                begin
                    comp_reg  <= 2'd0;
                    stage_reg <= 2'd0;
                end
                tar4_pkg::CS_FOLD:
                begin
                    op_reg <= tar4_pkg::OP_SQ;
                end
                tar4_pkg::CS_MWAIT:
                begin
                    if (mul_done)
                    begin
                        case (op_reg)
                            tar4_pkg::OP_SQ:
                            begin
                                hcnt_reg <= 3'd0;
                                op_reg   <= tar4_pkg::OP_HORN;
                            end
                            tar4_pkg::OP_HORN:
                            begin
                                if (hcnt_reg == 3'd4)
                                begin
                                    op_reg <= tar4_pkg::OP_SINF;
                                end
                                else
                                begin
                                    hcnt_reg <= hcnt_reg + 3'd1;
                                end
                            end
                            tar4_pkg::OP_SINF: op_reg <= tar4_pkg::OP_BU;
                            tar4_pkg::OP_BU:   op_reg <= tar4_pkg::OP_DK;
                            tar4_pkg::OP_DK:
                            begin
                                pos_reg[0] <= pos_reg[1];
                                pos_reg[1] <= pos_reg[2];
                                pos_reg[2] <= pos_reg[0];
                                if (comp_reg == 2'd2)
                                begin
                                    comp_reg  <= 2'd0;
                                    stage_reg <= stage_reg + 2'd1;
                                    if (stage_reg == 2'd3)
                                    begin
                                        op_reg <= tar4_pkg::OP_FIN;
                                    end
                                end
                                else
                                begin
                                    comp_reg <= comp_reg + 2'd1;
                                end
                            end
                            default:
                            begin
                                pos_reg[0] <= pos_reg[1];
                                pos_reg[1] <= pos_reg[2];
                                pos_reg[2] <= pos_sat;
                                comp_reg   <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tar4_pkg::CS_IDLE:
            begin
                if (cmd.start)
                begin
                    ksum_reg[0] <= '0;
                    ksum_reg[1] <= '0;
                    ksum_reg[2] <= '0;
                end
            end
            tar4_pkg::CS_ARG:
            begin
                u_reg <= RW'(pos_reg[0]) + half_k(stage_reg, kprev_reg[0]);
                r_reg <= (RW'(pos_reg[1]) + half_k(stage_reg, kprev_reg[1])) <<< 3;
            end
            tar4_pkg::CS_RED:
            begin
                if (r_reg >= tar4_pkg::Q30_PI)
                begin
                    r_reg <= r_reg - tar4_pkg::Q30_TWO_PI;
                end
                else if (r_reg < -tar4_pkg::Q30_PI)
                begin
                    r_reg <= r_reg + tar4_pkg::Q30_TWO_PI;
                end
            end
            tar4_pkg::CS_FOLD:
            begin
                if (r_reg > tar4_pkg::Q30_HALF_PI)
                begin
                    r_reg <= tar4_pkg::Q30_PI - r_reg;
                end
                else if (r_reg < -tar4_pkg::Q30_HALF_PI)
                begin
                    r_reg <= -tar4_pkg::Q30_PI - r_reg;
                end
            end
            tar4_pkg::CS_MWAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        tar4_pkg::OP_SQ:
                        begin
                            r2_reg <= RW'(prod >>> 30);
                            p_reg  <= tar4_pkg::HORNER_SEED;
                        end
                        tar4_pkg::OP_HORN:
                        begin
                            p_reg <= tar4_pkg::horner_coef(hcnt_reg) - BW'(prod >>> 30);
                        end
                        tar4_pkg::OP_SINF:
                        begin
                            sin_reg <= RW'(prod >>> 33);
                        end
                        tar4_pkg::OP_BU:
                        begin
                            d_reg <= sin_reg - RW'(prod >>> 24);
                        end
                        tar4_pkg::OP_DK:
                        begin
                            // The middle two stages count twice in the RK4 sum.
                            if (stage_reg == 2'd1 || stage_reg == 2'd2)
                            begin
                                ksum_reg[2] <= ksum_reg[0] + (k_new <<< 1);
                            end
                            else
                            begin
                                ksum_reg[2] <= ksum_reg[0] + k_new;
                            end
                            ksum_reg[0] <= ksum_reg[1];
                            ksum_reg[1] <= ksum_reg[2];
                            kcur_reg[0] <= kcur_reg[1];
                            kcur_reg[1] <= kcur_reg[2];
                            kcur_reg[2] <= k_new;
                            if (comp_reg == 2'd2)
                            begin
                                kprev_reg[0] <= kcur_reg[1];
                                kprev_reg[1] <= kcur_reg[2];
                                kprev_reg[2] <= k_new;
                            end
                            else
                            begin
                                kprev_reg[0] <= kprev_reg[1];
                                kprev_reg[1] <= kprev_reg[2];
                                kprev_reg[2] <= kprev_reg[0];
                            end
                        end
                        default:
                        begin
                            ksum_reg[0] <= ksum_reg[1];
                            ksum_reg[1] <= ksum_reg[2];
                            ksum_reg[2] <= ksum_reg[0];
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];

endmodule

`default_nettype wire

// File: rtl/thomas_attractor_rk4_step_unit.sv
// Per sample: twelve slopes, each with as many 2*pi reduction steps as its sine
// argument needs, then three final updates. All products go through the shared
// multiplier, nine products per slope. The samples of a block run one after
// another, and each waits while its result is stalled; one block is taken at a
// time. Reset restores (0.4, 0.3, 0.1).
// ----------------------------------------------------------------------------
// thomas_attractor_rk4_step_unit
// Thomas attractor oscillator: per request, advances the position by one
// RK4 step per sample and returns each new position.
// ----------------------------------------------------------------------------
`default_nettype none

module thomas_attractor_rk4_step_unit #(
    parameter int MAX_BLOCK = tar4_pkg::MAX_BLOCK_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire tar4_pkg::req_t  req,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output tar4_pkg::res_t       res
);

    localparam int CW = $clog2(MAX_BLOCK + 1);

    tar4_pkg::top_state_t state_reg;
    tar4_pkg::top_state_t state_next;
    tar4_pkg::rk_cmd_t    cmd;
    tar4_pkg::res_t       res_reg;

    logic [23:0]   dt_reg;
    logic [23:0]   damp_reg;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] count_clamped;
    logic          core_done;
    logic          req_accept;
    logic          res_accept;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    assign req_accept = req_valid && !req_stall;
    assign res_accept = res_valid && !res_stall;

    always_comb
    begin
        if (req.sample_count > 7'(MAX_BLOCK))
        begin
            count_clamped = CW'(MAX_BLOCK);
        end
        else
        begin
            count_clamped = CW'(req.sample_count);
        end
    end

    tar4_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .done  (core_done),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tar4_pkg::TS_IDLE:
            begin
                // A request with no samples is taken and dropped.
                if (req_valid && count_clamped != '0)
                begin
                    state_next = tar4_pkg::TS_START;
                end
            end
            tar4_pkg::TS_START: state_next = tar4_pkg::TS_RUN;
            tar4_pkg::TS_RUN:
            begin
                if (core_done)
                begin
                    state_next = tar4_pkg::TS_OUT;
                end
            end
            tar4_pkg::TS_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = res_reg.block_last ? tar4_pkg::TS_IDLE : tar4_pkg::TS_START;
                end
            end
            default: state_next = tar4_pkg::TS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req_stall = (state_reg != tar4_pkg::TS_IDLE);
        res_valid = (state_reg == tar4_pkg::TS_OUT);
        cmd.start = (state_reg == tar4_pkg::TS_START);
        cmd.dt    = dt_reg;
        cmd.damp  = damp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tar4_pkg::TS_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_accept)
            begin
                left_reg <= count_clamped;
            end
            else if (res_accept)
            begin
                left_reg <= left_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            dt_reg   <= req.step_size;
            damp_reg <= req.damping;
        end
        if (state_reg == tar4_pkg::TS_RUN && core_done)
        begin
            res_reg.x_out      <= pos_x;
            res_reg.y_out      <= pos_y;
            res_reg.z_out      <= pos_z;
            res_reg.block_last <= (left_reg == CW'(1));
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: rtl/tar4_checker.sv
// ----------------------------------------------------------------------------
// tar4_checker
// Port-level checks on the Thomas attractor RK4 step unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tar4_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_stall,
    input wire tar4_pkg::req_t  req,
    input wire logic            res_valid,
    input wire logic            res_stall,
    input wire tar4_pkg::res_t  res
);

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // A request with samples makes the block busy.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.sample_count != 7'd0 |=> req_stall)
        else $error("block not busy after request");

    // No new request is taken while a result is pending.
    a_no_req_during_res: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> req_stall)
        else $error("request taken while result pending");

    // Nothing follows the last result of a block.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res.block_last |=> !res_valid)
        else $error("result after last of block");

endmodule

bind thomas_attractor_rk4_step_unit tar4_checker u_tar4_checker (.*);

`default_nettype wire
